// ----- rtl/cpu_alu_with_flags_core_assert.svh -----
// Assertion macros used by the ALU core (cpu_alu_with_flags_core).
`ifndef CPU_ALU_WITH_FLAGS_CORE_ASSERT_SVH
`define CPU_ALU_WITH_FLAGS_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside reset.
`define CAF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define CAF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define CAF_ASSERT(name, prop, msg)
`define CAF_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ----- rtl/caf_pkg.sv -----
package caf_pkg;

  localparam int unsigned OpWidth   = 3;
  localparam int unsigned DataWidth = 16;
  localparam int unsigned ByteWidth = 8;

  localparam logic [OpWidth-1:0] OpAdd8      = 3'd0;
  localparam logic [OpWidth-1:0] OpSub8      = 3'd1;
  localparam logic [OpWidth-1:0] OpAdd16Low  = 3'd2;
  localparam logic [OpWidth-1:0] OpAdd16High = 3'd3;
  localparam logic [OpWidth-1:0] OpShift     = 3'd4;
  localparam logic [OpWidth-1:0] OpSra       = 3'd5;
  localparam logic [OpWidth-1:0] OpRotate    = 3'd6;
  localparam logic [OpWidth-1:0] OpRotateC   = 3'd7;

  typedef struct packed {
    logic [DataWidth-1:0] value;
    logic                 zero;
    logic                 subtract;
    logic                 half_carry;
    logic                 carry;
  } caf_result_t;

endpackage

// ----- rtl/cpu_alu_with_flags_core.sv -----
// A result passes the input register, then the result register, before out_valid_o rises;
// a stall on out_ready_i can hold an item in either register.
// Throughput: one item per cycle while out_ready_i is not held low; out_ready_i reaches in_ready_o combinationally.
// Reset (rst_ni low, asynchronous) empties both stages; payload registers are not reset.
`include "cpu_alu_with_flags_core_assert.svh"

module cpu_alu_with_flags_core import caf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [OpWidth-1:0]   op_i,
  input  logic [DataWidth-1:0] operand_a_i,
  input  logic [DataWidth-1:0] operand_b_i,
  input  logic                 carry_in_i,
  input  logic                 direction_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DataWidth-1:0] value_o,
  output logic                 flag_zero_o,
  output logic                 flag_subtract_o,
  output logic                 flag_half_carry_o,
  output logic                 flag_carry_o
);

  logic                 s1_valid_q;
  logic [OpWidth-1:0]   op_q;
  logic [DataWidth-1:0] operand_a_q;
  logic [DataWidth-1:0] operand_b_q;
  logic                 carry_in_q;
  logic                 direction_q;
  logic                 s1_ready;
  logic                 out_valid_q;
  caf_result_t          alu_res;
  caf_result_t          res_q;

  assign s1_ready   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q        <= op_i;
      operand_a_q <= operand_a_i;
      operand_b_q <= operand_b_i;
      carry_in_q  <= carry_in_i;
      direction_q <= direction_i;
    end
  end

  caf_alu u_alu (
    .op_i        (op_q),
    .operand_a_i (operand_a_q),
    .operand_b_i (operand_b_q),
    .carry_in_i  (carry_in_q),
    .direction_i (direction_q),
    .result_o    (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_ready) begin
      res_q <= alu_res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign value_o           = res_q.value;
  assign flag_zero_o       = res_q.zero;
  assign flag_subtract_o   = res_q.subtract;
  assign flag_half_carry_o = res_q.half_carry;
  assign flag_carry_o      = res_q.carry;

  `CAF_ASSERT(a_accept_fills_stage, in_valid_i && in_ready_o |=> s1_valid_q, "accepted item lost")
  `CAF_ASSERT(a_stage_holds, s1_valid_q && !s1_ready |=> s1_valid_q && $stable(op_q), "stage 1 item changed while stalled")
  `CAF_ASSERT(a_zero_flag, out_valid_o |-> (flag_zero_o == (value_o == '0)), "Z flag disagrees with value")
  `CAF_ASSERT(a_sub_upper_zero, out_valid_o && flag_subtract_o |-> value_o[15:8] == '0, "subtract result upper byte not zero")
  `CAF_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o && !s1_valid_q, "pipeline not empty in reset")

endmodule

// ----- rtl/caf_alu.sv -----
module caf_alu import caf_pkg::*; (
  input  logic [OpWidth-1:0]   op_i,
  input  logic [DataWidth-1:0] operand_a_i,
  input  logic [DataWidth-1:0] operand_b_i,
  input  logic                 carry_in_i,
  input  logic                 direction_i,
  output caf_result_t          result_o
);

  logic [ByteWidth-1:0] a8;
  logic [ByteWidth:0]   sum8;
  logic [ByteWidth:0]   diff8;
  logic [4:0]           nib_sum;
  logic [4:0]           nib_diff;
  logic [4:0]           nib_sum16;
  logic [12:0]          sum12;
  logic [DataWidth:0]   sum16;
  logic [DataWidth-1:0] value;

  assign a8 = operand_a_i[7:0];

  assign sum8      = {1'b0, a8} + {1'b0, operand_b_i[7:0]} + {8'd0, carry_in_i};
  assign nib_sum   = {1'b0, a8[3:0]} + {1'b0, operand_b_i[3:0]} + {4'd0, carry_in_i};
  // Bit 8 and bit 4 of the differences are the byte and nibble borrows.
  assign diff8     = {1'b0, a8} - {1'b0, operand_b_i[7:0]} - {8'd0, carry_in_i};
  assign nib_diff  = {1'b0, a8[3:0]} - {1'b0, operand_b_i[3:0]} - {4'd0, carry_in_i};
  assign nib_sum16 = {1'b0, operand_a_i[3:0]} + {1'b0, operand_b_i[3:0]};
  assign sum12     = {1'b0, operand_a_i[11:0]} + {1'b0, operand_b_i[11:0]};
  assign sum16     = {1'b0, operand_a_i} + {1'b0, operand_b_i};

  always_comb begin
    value               = '0;
    result_o.subtract   = 1'b0;
    result_o.half_carry = 1'b0;
    result_o.carry      = 1'b0;
    case (op_i)
      OpAdd8: begin
        value[7:0]          = sum8[7:0];
        result_o.half_carry = nib_sum[4];
        result_o.carry      = sum8[8];
      end
      OpSub8: begin
        value[7:0]          = diff8[7:0];
        result_o.subtract   = 1'b1;
        result_o.half_carry = nib_diff[4];
        result_o.carry      = diff8[8];
      end
      OpAdd16Low: begin
        value               = sum16[15:0];
        result_o.half_carry = nib_sum16[4];
        // Carry out of bit 7 of the full sum equals that of the low bytes alone.
        result_o.carry      = sum16[8] ^ operand_a_i[8] ^ operand_b_i[8];
      end
      OpAdd16High: begin
        value               = sum16[15:0];
        result_o.half_carry = sum12[12];
        result_o.carry      = sum16[16];
      end
      OpShift: begin
        if (direction_i) begin
          value[7:0]     = {1'b0, a8[7:1]};
          result_o.carry = a8[0];
        end else begin
          value[7:0]     = {a8[6:0], 1'b0};
          result_o.carry = a8[7];
        end
      end
      OpSra: begin
        value[7:0]     = {a8[7], a8[7:1]};
        result_o.carry = a8[0];
      end
      OpRotate: begin
        if (direction_i) begin
          value[7:0]     = {a8[0], a8[7:1]};
          result_o.carry = a8[0];
        end else begin
          value[7:0]     = {a8[6:0], a8[7]};
          result_o.carry = a8[7];
        end
      end
      OpRotateC: begin
        if (direction_i) begin
          value[7:0]     = {carry_in_i, a8[7:1]};
          result_o.carry = a8[0];
        end else begin
          value[7:0]     = {a8[6:0], carry_in_i};
          result_o.carry = a8[7];
        end
      end
      default: begin
        value = '0;
      end
    endcase
    result_o.value = value;
    result_o.zero  = (value == '0);
  end

endmodule

// ----- tb/tb_cpu_alu_with_flags_core.sv -----
`timescale 1ns / 1ps

module tb_cpu_alu_with_flags_core;
  import caf_pkg::*;

  localparam int unsigned ResetCycles   = 6;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned WatchdogLimit = 2000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [OpWidth-1:0]   op_i;
  logic [DataWidth-1:0] operand_a_i;
  logic [DataWidth-1:0] operand_b_i;
  logic                 carry_in_i;
  logic                 direction_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [DataWidth-1:0] value_o;
  logic                 flag_zero_o;
  logic                 flag_subtract_o;
  logic                 flag_half_carry_o;
  logic                 flag_carry_o;

  caf_result_t alu_expected_q[$];
  int unsigned fail_count;
  bit          idle_en;

  cpu_alu_with_flags_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .operand_a_i      (operand_a_i),
    .operand_b_i      (operand_b_i),
    .carry_in_i       (carry_in_i),
    .direction_i      (direction_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .value_o          (value_o),
    .flag_zero_o      (flag_zero_o),
    .flag_subtract_o  (flag_subtract_o),
    .flag_half_carry_o(flag_half_carry_o),
    .flag_carry_o     (flag_carry_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic caf_result_t predict_alu(input logic [OpWidth-1:0] op,
                                              input logic [DataWidth-1:0] a,
                                              input logic [DataWidth-1:0] b,
                                              input logic cin,
                                              input logic dir);
    caf_result_t res;
    logic [7:0]  a8;
    logic [7:0]  b8;
    logic [4:0]  nib_sum;
    logic [8:0]  byte_sum;
    logic [12:0] sum12;
    logic [16:0] sum16;
    logic [7:0]  nib_diff;
    res = '0;
    a8  = a[7:0];
    b8  = b[7:0];
    case (op)
      OpAdd8: begin
        nib_sum        = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'b0, cin};
        byte_sum       = {1'b0, a8} + {1'b0, b8} + {8'b0, cin};
        res.half_carry = nib_sum[4];
        res.carry      = byte_sum[8];
        res.value      = {8'h00, byte_sum[7:0]};
      end
      OpSub8: begin
        // A negative nibble difference wraps high, so bit 5 marks the borrow.
        nib_diff       = {4'h0, a8[3:0]} - {4'h0, b8[3:0]} - {7'b0, cin};
        res.half_carry = nib_diff[5];
        res.carry      = ({1'b0, a8} < ({1'b0, b8} + {8'b0, cin}));
        res.value      = {8'h00, a8 - b8 - {7'b0, cin}};
        res.subtract   = 1'b1;
      end
      OpAdd16Low: begin
        nib_sum        = {1'b0, a[3:0]} + {1'b0, b[3:0]};
        byte_sum       = {1'b0, a[7:0]} + {1'b0, b[7:0]};
        sum16          = {1'b0, a} + {1'b0, b};
        res.half_carry = nib_sum[4];
        res.carry      = byte_sum[8];
        res.value      = sum16[15:0];
      end
      OpAdd16High: begin
        sum12          = {1'b0, a[11:0]} + {1'b0, b[11:0]};
        sum16          = {1'b0, a} + {1'b0, b};
        res.half_carry = sum12[12];
        res.carry      = sum16[16];
        res.value      = sum16[15:0];
      end
      OpShift: begin
        res.carry = dir ? a8[0] : a8[7];
        res.value = {8'h00, (dir ? {1'b0, a8[7:1]} : {a8[6:0], 1'b0})};
      end
      OpSra: begin
        res.carry = a8[0];
        res.value = {8'h00, a8[7], a8[7:1]};
      end
      OpRotate: begin
        res.carry = dir ? a8[0] : a8[7];
        res.value = {8'h00, (dir ? {a8[0], a8[7:1]} : {a8[6:0], a8[7]})};
      end
      OpRotateC: begin
        res.carry = dir ? a8[0] : a8[7];
        res.value = {8'h00, (dir ? {cin, a8[7:1]} : {a8[6:0], cin})};
      end
      default: ;
    endcase
    res.zero = (res.value == '0);
    return res;
  endfunction

  function automatic logic [DataWidth-1:0] pick_operand();
    logic [DataWidth-1:0] corners[6];
    corners = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00, 16'h000F, 16'h0FFF};
    if ($urandom_range(0, 7) == 0) begin
      return corners[$urandom_range(0, 5)];
    end
    return DataWidth'($urandom);
  endfunction

  task automatic send_item(input logic [OpWidth-1:0] op, input logic [DataWidth-1:0] a,
                           input logic [DataWidth-1:0] b, input logic cin,
                           input logic dir);
    int unsigned gap;
    if (idle_en && ($urandom_range(0, 5) == 0)) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    carry_in_i  <= cin;
    direction_i <= dir;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    alu_expected_q.push_back(predict_alu(op, a, b, cin, dir));
  endtask

  task automatic send_random_item();
    send_item(OpWidth'($urandom_range(0, 7)), pick_operand(), pick_operand(),
              1'($urandom), 1'($urandom));
  endtask

  task automatic test_add_sub_extremes();
    send_item(OpAdd8,      16'h0000, 16'h0000, 1'b0, 1'b0);
    send_item(OpAdd8,      16'h00FF, 16'h0001, 1'b0, 1'b1);
    // Upper bytes must not leak into 8-bit arithmetic.
    send_item(OpAdd8,      16'hAB0F, 16'hCD00, 1'b1, 1'b0);
    send_item(OpAdd8,      16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_item(OpSub8,      16'h0000, 16'h0000, 1'b0, 1'b0);
    send_item(OpSub8,      16'h0000, 16'h0001, 1'b0, 1'b0);
    send_item(OpSub8,      16'h0010, 16'h0001, 1'b0, 1'b1);
    send_item(OpSub8,      16'h12FF, 16'h34FF, 1'b1, 1'b0);
    send_item(OpSub8,      16'h0080, 16'h007F, 1'b1, 1'b0);
    send_item(OpAdd16Low,  16'hFFFF, 16'h0001, 1'b0, 1'b0);
    send_item(OpAdd16Low,  16'h000F, 16'h0001, 1'b1, 1'b1);
    // The high-byte flags see the carry rippling up from the low byte.
    send_item(OpAdd16High, 16'h0FFF, 16'h0001, 1'b0, 1'b0);
    send_item(OpAdd16High, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    send_item(OpAdd16High, 16'h8000, 16'h8000, 1'b0, 1'b0);
  endtask

  task automatic test_shift_rotate_cases();
    send_item(OpShift,   16'h1280, 16'hFFFF, 1'b1, 1'b0);
    send_item(OpShift,   16'h0001, 16'h0000, 1'b0, 1'b1);
    send_item(OpShift,   16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_item(OpShift,   16'hFFFF, 16'h0000, 1'b1, 1'b1);
    send_item(OpSra,     16'h0081, 16'h0000, 1'b0, 1'b0);
    send_item(OpSra,     16'hFF00, 16'hFFFF, 1'b1, 1'b1);
    send_item(OpRotate,  16'h0080, 16'h0000, 1'b0, 1'b0);
    send_item(OpRotate,  16'h0001, 16'h0000, 1'b1, 1'b1);
    // Through carry, the old carry enters at the vacated end.
    send_item(OpRotateC, 16'h0001, 16'h0000, 1'b0, 1'b1);
    send_item(OpRotateC, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_item(OpRotateC, 16'h0080, 16'h0000, 1'b0, 1'b0);
    send_item(OpRotateC, 16'h0000, 16'h0000, 1'b1, 1'b0);
  endtask

  task automatic test_random_ops(input int unsigned count);
    repeat (count) send_random_item();
  endtask

  task automatic test_drain_pause();
    repeat (30) send_random_item();
    in_valid_i <= 1'b0;
    while (alu_expected_q.size() != 0) @(posedge clk_i);
    repeat (30) send_random_item();
  endtask

  // The sink stalls in random bursts while idling is enabled.
  initial begin : sink_ready
    int unsigned stall;
    out_ready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (idle_en && ($urandom_range(0, 7) == 0)) begin
        stall = $urandom_range(1, 12);
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic report_mismatch(input string field, input logic [DataWidth-1:0] want,
                                 input logic [DataWidth-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    caf_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (alu_expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual value %h",
                 $time, value_o);
        fail_count++;
      end else begin
        want = alu_expected_q.pop_front();
        report_mismatch("value", want.value, value_o);
        report_mismatch("flag_zero", 16'(want.zero), 16'(flag_zero_o));
        report_mismatch("flag_subtract", 16'(want.subtract), 16'(flag_subtract_o));
        report_mismatch("flag_half_carry", 16'(want.half_carry), 16'(flag_half_carry_o));
        report_mismatch("flag_carry", 16'(want.carry), 16'(flag_carry_o));
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no item moved for %0d cycles", $time, WatchdogLimit);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main_seq
    fail_count = 0;
    idle_en    = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    op_i        <= OpAdd8;
    operand_a_i <= '0;
    operand_b_i <= '0;
    carry_in_i  <= 1'b0;
    direction_i <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_add_sub_extremes();
    test_shift_rotate_cases();
    idle_en = 1'b1;
    test_random_ops(700);
    test_drain_pause();
    test_random_ops(600);
    idle_en = 1'b0;
    test_random_ops(200);

    in_valid_i <= 1'b0;
    while (alu_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/caf_pkg.sv
rtl/caf_alu.sv
rtl/cpu_alu_with_flags_core.sv
tb/tb_cpu_alu_with_flags_core.sv
